// ===== hdl/ddo_pkg.sv =====
// Package: shared constants, tables, state and command types for the odometry block.
package ddo_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int CORDIC_ITER_DEF  = 24;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PER_DIFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE   = 2'd2;

  // item command codes
  localparam logic CMD_ORIGIN = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [31:0] DIST_PER_COUNT_RST = 32'd455393;
  localparam logic [23:0] ANGLE_PER_DIFF_RST = 24'd252537;
  localparam logic [31:0] STOP_DISTANCE_RST  = 32'd3355443;

  // CORDIC start vector: reciprocal of the limit gain, Q2.30
  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;

  localparam logic [31:0] ATAN_LUT [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_T, ST_MUL_H, ST_ANGLE, ST_ROT,
    ST_MUL_X, ST_MUL_Y, ST_POSE_Y, ST_DONE
  } ddo_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL_T, OP_MUL_H, OP_ANGLE,
    OP_ROT, OP_MUL_X, OP_MUL_Y, OP_POSE_Y
  } ddo_op_e;

  typedef struct packed {
    ddo_op_e     op;
    logic [4:0]  step;      // CORDIC iteration index
    logic        out_load;  // move pose into the output register
  } ddo_cmd_t;

  typedef struct packed {
    logic rot_last;
  } ddo_status_t;

endpackage

// ===== hdl/ddo_if.sv =====
// Interfaces: input item channel and result item channel.
interface ddo_in_if #(
  parameter int COUNTER_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [COUNTER_BITS-1:0] right_count;
  logic [COUNTER_BITS-1:0] left_count;

  modport source (output valid, command, right_count, left_count, input ready);
  modport sink   (input valid, command, right_count, left_count, output ready);
endinterface

interface ddo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_position;
  logic [31:0] y_position;
  logic [31:0] heading;
  logic        stop_request;

  modport source (output valid, x_position, y_position, heading, stop_request,
                  input ready);
  modport sink   (input valid, x_position, y_position, heading, stop_request,
                  output ready);
endinterface

// ===== hdl/ddo_ctrl.sv =====
// Controller: sequences one item through the datapath and owns the handshakes.
module ddo_ctrl #(
  parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITER_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ddo_pkg::ddo_status_t status_i,
  output ddo_pkg::ddo_cmd_t    cmd_o
);
  import ddo_pkg::*;

  localparam int IW = $clog2(CORDIC_ITERATIONS);

  ddo_state_e    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.op     = OP_NONE;
    cmd_o.step   = 5'(cnt_q);
    cmd_o.out_load = 1'b0;
    in_ready_o   = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = in_command_i ? ST_MUL_T : ST_DONE;
        end
      end
      ST_MUL_T: begin
        cmd_o.op = OP_MUL_T;
        state_d  = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd_o.op = OP_MUL_H;
        state_d  = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd_o.op = OP_ANGLE;
        cnt_d    = '0;
        state_d  = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.op = OP_ROT;
        if (status_i.rot_last) begin
          state_d = ST_MUL_X;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MUL_X: begin
        cmd_o.op = OP_MUL_X;
        state_d  = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd_o.op = OP_MUL_Y;
        state_d  = ST_POSE_Y;
      end
      ST_POSE_Y: begin
        cmd_o.op = OP_POSE_Y;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ddo_datapath.sv =====
// Datapath: deltas, shared multiplier, CORDIC rotator, pose and config registers.
module ddo_datapath #(
  parameter int COUNTER_BITS      = ddo_pkg::COUNTER_BITS_DEF,
  parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITER_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 command_i,
  input  logic [COUNTER_BITS-1:0]              right_count_i,
  input  logic [COUNTER_BITS-1:0]              left_count_i,
  input  ddo_pkg::ddo_cmd_t                    cmd_i,
  output ddo_pkg::ddo_status_t                 status_o,
  output logic [31:0]                          x_position_o,
  output logic [31:0]                          y_position_o,
  output logic [31:0]                          heading_o,
  output logic                                 stop_request_o
);
  import ddo_pkg::*;

  localparam int CB = COUNTER_BITS;
  localparam int AW = (CB + 2 > 33) ? CB + 2 : 33;   // signed multiplier operand A
  localparam int BW = 34;                            // signed multiplier operand B
  localparam int PW = AW + BW;
  localparam int XW = 34;                            // CORDIC vector and angle width

  // configuration
  logic [31:0] dpc_q, stop_q;
  logic [23:0] apc_q;

  // state
  logic [CB-1:0] prev_r_q, prev_l_q;
  logic [31:0]   pose_x_q, pose_y_q, heading_q;

  // working registers
  logic [CB:0]           mag_sum_q, mag_diff_q;
  logic                  neg_sum_q, neg_diff_q, flip_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [31:0]    travel_q;
  logic signed [XW-1:0]  cx_q, cy_q, cz_q;

  // output register
  logic [31:0] out_x_q, out_y_q, out_h_q;
  logic        out_stop_q;

  // deltas
  logic [CB-1:0]      dr, dl;
  logic signed [CB:0] sum, diff;
  always_comb begin
    dr   = right_count_i - prev_r_q;
    dl   = left_count_i - prev_l_q;
    sum  = $signed({dr[CB-1], dr}) + $signed({dl[CB-1], dl});
    diff = $signed({dr[CB-1], dr}) - $signed({dl[CB-1], dl});
  end

  // travel rounding and saturation
  logic [PW-1:0]      tw;
  logic signed [31:0] travel_sat;
  always_comb begin
    tw = (prod_q + PW'(256)) >> 9;
    if (!neg_sum_q) begin
      travel_sat = (tw > PW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(tw[31:0]);
    end else begin
      travel_sat = (tw > PW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(tw[31:0]);
    end
  end

  // midpoint angle and heading change
  logic [31:0] dtheta, mid, mid_rot;
  logic        mid_flip;
  always_comb begin
    dtheta   = neg_diff_q ? -prod_q[31:0] : prod_q[31:0];
    mid      = heading_q + (neg_diff_q ? -prod_q[32:1] : prod_q[32:1]);
    mid_flip = mid[31] ^ mid[30];
    mid_rot  = mid ^ {mid_flip, 31'd0};
  end

  // one CORDIC rotation step; arithmetic shifts are floor shifts
  logic signed [XW-1:0] sx, sy, atan_v;
  always_comb begin
    sx     = cx_q >>> cmd_i.step;
    sy     = cy_q >>> cmd_i.step;
    atan_v = $signed({2'b00, ATAN_LUT[cmd_i.step]});
  end

  // shared multiplier operands
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [XW-1:0] cos_v, sin_v;
  always_comb begin
    cos_v = flip_q ? -cx_q : cx_q;
    sin_v = flip_q ? -cy_q : cy_q;
    unique case (cmd_i.op)
      OP_MUL_T: begin
        mul_a = $signed(AW'(mag_sum_q));
        mul_b = $signed(BW'(dpc_q));
      end
      OP_MUL_H: begin
        mul_a = $signed(AW'(mag_diff_q));
        mul_b = $signed(BW'(apc_q));
      end
      OP_MUL_Y: begin
        mul_a = AW'(travel_q);
        mul_b = sin_v;
      end
      default: begin
        mul_a = AW'(travel_q);
        mul_b = cos_v;
      end
    endcase
  end

  // increment rounding and saturating accumulate
  logic signed [PW-1:0] inc, acc_x, acc_y;
  logic signed [31:0]   new_x, new_y;
  always_comb begin
    inc   = (prod_q + PW'(64'sd536870912)) >>> 30;
    acc_x = PW'($signed(pose_x_q)) + inc;
    acc_y = PW'($signed(pose_y_q)) + inc;
    if (acc_x > PW'(32'sh7FFF_FFFF)) begin
      new_x = 32'sh7FFF_FFFF;
    end else if (acc_x < PW'(32'sh8000_0000)) begin
      new_x = 32'sh8000_0000;
    end else begin
      new_x = acc_x[31:0];
    end
    if (acc_y > PW'(32'sh7FFF_FFFF)) begin
      new_y = 32'sh7FFF_FFFF;
    end else if (acc_y < PW'(32'sh8000_0000)) begin
      new_y = 32'sh8000_0000;
    end else begin
      new_y = acc_y[31:0];
    end
  end

  assign status_o.rot_last = (cmd_i.step == 5'(CORDIC_ITERATIONS - 1));

  // config and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q     <= DIST_PER_COUNT_RST;
      apc_q     <= ANGLE_PER_DIFF_RST;
      stop_q    <= STOP_DISTANCE_RST;
      prev_r_q  <= '0;
      prev_l_q  <= '0;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_DIST_PER_COUNT) dpc_q  <= cfg_data_i;
        if (cfg_index_i == REG_ANGLE_PER_DIFF) apc_q  <= cfg_data_i[23:0];
        if (cfg_index_i == REG_STOP_DISTANCE)  stop_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_LOAD) begin
        prev_r_q <= right_count_i;
        prev_l_q <= left_count_i;
        if (!command_i) begin
          pose_x_q  <= '0;
          pose_y_q  <= '0;
          heading_q <= '0;
        end
      end
      if (cmd_i.op == OP_ANGLE) heading_q <= heading_q + dtheta;
      if (cmd_i.op == OP_MUL_Y) pose_x_q  <= new_x;
      if (cmd_i.op == OP_POSE_Y) pose_y_q <= new_y;
    end
  end

  // working registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      neg_sum_q  <= sum[CB];
      neg_diff_q <= diff[CB];
      mag_sum_q  <= sum[CB] ? -sum : sum;
      mag_diff_q <= diff[CB] ? -diff : diff;
    end
    if (cmd_i.op == OP_MUL_T || cmd_i.op == OP_MUL_H ||
        cmd_i.op == OP_MUL_X || cmd_i.op == OP_MUL_Y) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.op == OP_MUL_H) travel_q <= travel_sat;
    if (cmd_i.op == OP_ANGLE) begin
      flip_q <= mid_flip;
      cx_q   <= XW'(INV_GAIN_Q30);
      cy_q   <= '0;
      cz_q   <= XW'($signed(mid_rot));
    end
    if (cmd_i.op == OP_ROT) begin
      if (!cz_q[XW-1]) begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + atan_v;
      end
    end
    if (cmd_i.out_load) begin
      out_x_q    <= pose_x_q;
      out_y_q    <= pose_y_q;
      out_h_q    <= heading_q;
      out_stop_q <= ($signed(pose_x_q) >= $signed(stop_q));
    end
  end

  assign x_position_o   = out_x_q;
  assign y_position_o   = out_y_q;
  assign heading_o      = out_h_q;
  assign stop_request_o = out_stop_q;

endmodule

// ===== hdl/differential_drive_odometry.sv =====
// Top level: differential-drive dead-reckoning odometry with CORDIC heading rotation.
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+-----------
//  in_item  | in  | command, right_count, left_count              | valid/ready
//  out_item | out | x_position, y_position, heading, stop_request | valid/ready
//  cfg      | in  | cfg_index_i, cfg_data_i                       | cfg_we_i
//
// An update item runs CORDIC_ITERATIONS rotator iterations, one per cycle,
// plus four passes through the shared multiplier. An origin item goes
// straight from its load to the final output load.
// One item is in work at a time; in_item.ready is high only when idle.
// A finished result waits in the output register; while it waits the next
// item is accepted and only its own final load stalls on out_item.ready.
// Reset (async, active low) restores the config defaults and zeroes the pose, heading and previous counts.
module differential_drive_odometry #(
  parameter int COUNTER_BITS      = ddo_pkg::COUNTER_BITS_DEF,
  parameter int CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITER_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ddo_in_if.sink                         in_item,
  ddo_out_if.source                      out_item
);
  import ddo_pkg::*;

  ddo_cmd_t    cmd;
  ddo_status_t status;

  // controller: state sequence, iteration count, handshakes
  ddo_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_item.valid),
    .in_command_i (in_item.command),
    .in_ready_o   (in_item.ready),
    .out_valid_o  (out_item.valid),
    .out_ready_i  (out_item.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // datapath: config, pose state, multiplier, rotator, output register
  ddo_datapath #(
    .COUNTER_BITS      (COUNTER_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (in_item.command),
    .right_count_i  (in_item.right_count),
    .left_count_i   (in_item.left_count),
    .cmd_i          (cmd),
    .status_o       (status),
    .x_position_o   (out_item.x_position),
    .y_position_o   (out_item.y_position),
    .heading_o      (out_item.heading),
    .stop_request_o (out_item.stop_request)
  );

endmodule

// ===== hdl/ddo_checker.sv =====
// Checker: port-level assertions for the odometry block, bound to the top level.
module ddo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_x_i,
  input logic [31:0] out_y_i,
  input logic [31:0] out_h_i,
  input logic        out_stop_i
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // a result only appears while the block is working on an item
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i)
      && $stable(out_h_i) && $stable(out_stop_i))
    else $error("stalled result changed");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_item.valid),
  .in_ready_i  (in_item.ready),
  .out_valid_i (out_item.valid),
  .out_ready_i (out_item.ready),
  .out_x_i     (out_item.x_position),
  .out_y_i     (out_item.y_position),
  .out_h_i     (out_item.heading),
  .out_stop_i  (out_item.stop_request)
);
